[src/circular_deque_ring_core_macros.svh]
// Assertion helpers for the deque datapath RTL.
// Each macro expects clk and rst to be visible in the calling module.
`ifndef CIRCULAR_DEQUE_RING_CORE_MACROS_SVH
`define CIRCULAR_DEQUE_RING_CORE_MACROS_SVH

// Condition holds at every edge outside reset.
`define DQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define DQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/cdq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

  typedef enum logic [2:0] {
    ACT_PUSH_HEAD = 3'd0,
    ACT_PUSH_TAIL = 3'd1,
    ACT_POP_HEAD  = 3'd2,
    ACT_POP_TAIL  = 3'd3,
    ACT_DUMP      = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DUMP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    wr_head;   // push at head
    logic    wr_tail;   // push at tail
    logic    rd_head;   // pop at head, read issued
    logic    rd_tail;   // pop at tail, read issued
    logic    rd_first;  // dump: read head entry
    logic    rd_next;   // dump: read following entry
    logic    emit_imm;  // result with zero word and given code
    logic    emit_mem;  // result carrying the RAM read word
    logic    mem_last;  // last flag for a RAM result
    status_t code;      // status for an immediate result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic more;  // dump has entries left to read
  } stat_t;

endpackage

`default_nettype wire

[src/cdq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/cdq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [2:0] action,
  input  wire stat_t      stat,
  output logic            busy,
  output cmd_t            cmd
);

  state_t  state;
  state_t  state_next;
  action_t act;

  assign act = action_t'(action);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (act) inside
            ACT_PUSH_HEAD, ACT_PUSH_TAIL: begin
              cmd.emit_imm = 1'b1;
              if (stat.full) begin
                cmd.code = ST_FULL;
              end else begin
                cmd.code    = ST_OK;
                cmd.wr_head = (act == ACT_PUSH_HEAD);
                cmd.wr_tail = (act == ACT_PUSH_TAIL);
              end
            end
            ACT_POP_HEAD, ACT_POP_TAIL: begin
              if (stat.empty) begin
                cmd.emit_imm = 1'b1;
                cmd.code     = ST_EMPTY;
              end else begin
                cmd.rd_head = (act == ACT_POP_HEAD);
                cmd.rd_tail = (act == ACT_POP_TAIL);
                state_next  = S_POP;
              end
            end
            ACT_DUMP: begin
              if (stat.empty) begin
                cmd.emit_imm = 1'b1;
                cmd.code     = ST_EMPTY;
              end else begin
                cmd.rd_first = 1'b1;
                state_next   = S_DUMP;
              end
            end
            default: begin
              // unused codes: no result, no state change
            end
          endcase
        end
      end
      S_POP: begin
        cmd.emit_mem = 1'b1;
        cmd.mem_last = 1'b1;
        state_next   = S_IDLE;
      end
      S_DUMP: begin
        cmd.emit_mem = 1'b1;
        cmd.mem_last = !stat.more;
        if (stat.more) begin
          cmd.rd_next = 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/cdq_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "circular_deque_ring_core_macros.svh"

module cdq_datapath
  import cdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cmd_t                       cmd,
  input  wire logic signed [31:0]         push_value,
  output stat_t                           stat,
  output logic                            strobe,
  output logic signed [31:0]              elem_value,
  output logic [1:0]                      status,
  output logic                            last,
  output logic [$clog2(DEPTH+1)-1:0]      fill_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;  // head + offset, below 2*DEPTH

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] idx;          // next dump offset to read

  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [SW-1:0] sum_tail;
  logic [SW-1:0] sum_back;
  logic [SW-1:0] sum_idx;
  logic [AW-1:0] pos_tail;     // slot after the back element
  logic [AW-1:0] pos_back;     // back element
  logic [AW-1:0] pos_idx;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  // ring index arithmetic, one compare-and-wrap each
  always_comb begin
    head_dec = (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;
    head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
    sum_tail = SW'(head) + SW'(count);
    sum_back = SW'(head) + SW'(count) - 1'b1;
    sum_idx  = SW'(head) + SW'(idx);
    pos_tail = (sum_tail >= SW'(DEPTH)) ? AW'(sum_tail - SW'(DEPTH)) : AW'(sum_tail);
    pos_back = (sum_back >= SW'(DEPTH)) ? AW'(sum_back - SW'(DEPTH)) : AW'(sum_back);
    pos_idx  = (sum_idx >= SW'(DEPTH)) ? AW'(sum_idx - SW'(DEPTH)) : AW'(sum_idx);
  end

  always_comb begin
    head_next  = head;
    count_next = count;
    if (cmd.wr_head) begin
      head_next = head_dec;
    end else if (cmd.rd_head) begin
      head_next = head_inc;
    end
    if (cmd.wr_head || cmd.wr_tail) begin
      count_next = count + 1'b1;
    end else if (cmd.rd_head || cmd.rd_tail) begin
      count_next = count - 1'b1;
    end
  end

  assign ram_we    = cmd.wr_head || cmd.wr_tail;
  assign ram_waddr = cmd.wr_head ? head_dec : pos_tail;
  assign ram_re    = cmd.rd_head || cmd.rd_tail || cmd.rd_first || cmd.rd_next;

  always_comb begin
    ram_raddr = head;
    if (cmd.rd_tail) begin
      ram_raddr = pos_back;
    end else if (cmd.rd_next) begin
      ram_raddr = pos_idx;
    end
  end

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.more  = (idx < count);

  cdq_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata($unsigned(push_value)),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      count  <= '0;
      idx    <= '0;
      strobe <= 1'b0;
    end else begin
      head   <= head_next;
      count  <= count_next;
      strobe <= cmd.emit_imm || cmd.emit_mem;
      if (cmd.rd_first) begin
        idx <= CW'(1);
      end else if (cmd.rd_next) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    fill_count <= count_next;
    if (cmd.emit_mem) begin
      elem_value <= $signed(ram_rdata);
      status     <= ST_OK;
      last       <= cmd.mem_last;
    end else begin
      elem_value <= '0;
      status     <= cmd.code;
      last       <= 1'b1;
    end
  end

  `DQ_ASSERT_ALWAYS(a_count_range, count <= CW'(DEPTH), "element count above depth")
  `DQ_ASSERT_ALWAYS(a_no_rw_clash, !(ram_we && ram_re), "RAM read and write in one cycle")
  `DQ_ASSERT_SAME(a_dump_in_range, cmd.rd_next, idx < count, "dump read past back element")
  `DQ_ASSERT_NEXT(a_push_grows, ram_we, count == $past(count) + 1'b1, "push did not grow count")

endmodule

`default_nettype wire

[src/circular_deque_ring_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Timing: push, full push, empty pop and empty dump give one result in the cycle after accept;
//   a pop gives its result after the registered RAM read and then the registered result word.
// Throughput: pushes 1 word per cycle while busy is low; a pop holds busy until its RAM word is read;
//   a dump holds busy and delivers its N entries back to back, set by the single RAM read port.
// Reset (rst, synchronous): head, count, FSM and strobe cleared; RAM contents not cleared.
// Results are never stalled: each sits on the output ports for exactly one strobe cycle.

module circular_deque_ring_core
  import cdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // command side: word taken when start is high and busy low
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [2:0]                 action,
  input  wire logic signed [31:0]         push_value,
  // result side: one word per strobe cycle
  output logic                            strobe,
  output logic signed [31:0]              elem_value,
  output logic [1:0]                      status,
  output logic                            last,
  output logic [$clog2(DEPTH+1)-1:0]      fill_count
);

  cmd_t  cmd;
  stat_t stat;

  // Controller decodes the action and sequences pops and dumps;
  // in idle it also decides full/empty outcomes on the spot.
  cdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .action(action),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Datapath keeps head index and count, owns the ring RAM and the
  // registered result word.
  cdq_datapath #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .push_value(push_value),
    .stat      (stat),
    .strobe    (strobe),
    .elem_value(elem_value),
    .status    (status),
    .last      (last),
    .fill_count(fill_count)
  );

endmodule

`default_nettype wire
